### rtl/core/crc8_framed_packet_receiver_macros.svh
// Assertion helpers for the packet receiver.
`ifndef CRC8_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFPR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("receiver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("receiver assertion failed");

`endif

### rtl/core/cfpr_pkg.sv
package cfpr_pkg;

    localparam int PAYLOAD_MAX = 32;
    localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [BYTE_W-1:0] CRC_POLY     = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_MSB      = 8'h80;
    localparam logic [BYTE_W-1:0] SYNC1_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC2_RESET  = 8'h55;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_TYPE,
        ST_LEN,
        ST_PAYLOAD,
        ST_CRC,
        ST_RD_ISSUE,
        ST_RD_LOAD
    } state_t;

    typedef struct packed {
        logic load_type;
        logic load_len;
        logic store_byte;
        logic rd_start;
        logic rd_next;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic len_zero;
        logic len_fits;
        logic fill_done;
        logic crc_ok;
        logic rd_last;
        logic out_free;
    } status_t;

    // CRC-8, MSB first, one byte per call.
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = acc ^ data;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if ((c & CRC_MSB) != '0)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/cfpr_ram.sv
module cfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/cfpr_ctrl.sv
module cfpr_ctrl
    import cfpr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = state_reg inside {ST_SYNC1, ST_SYNC2, ST_TYPE, ST_LEN, ST_PAYLOAD,
                                       ST_CRC};
        beat       = in_valid && in_ready;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_SYNC1:
            begin
                if (beat && status.sync1_hit)
                begin
                    state_next = ST_SYNC2;
                end
            end
            ST_SYNC2:
            begin
                if (beat)
                begin
                    state_next = status.sync2_hit ? ST_TYPE : ST_SYNC1;
                end
            end
            ST_TYPE:
            begin
                if (beat)
                begin
                    cmd.load_type = 1'b1;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (beat)
                begin
                    cmd.load_len = 1'b1;
                    if (status.len_zero)
                    begin
                        state_next = ST_CRC;
                    end
                    else if (status.len_fits)
                    begin
                        state_next = ST_PAYLOAD;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (beat)
                begin
                    cmd.store_byte = 1'b1;
                    if (status.fill_done)
                    begin
                        state_next = ST_CRC;
                    end
                end
            end
            ST_CRC:
            begin
                if (beat)
                begin
                    if (status.crc_ok)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = ST_RD_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_LOAD;
            end
            ST_RD_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_RD_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_SYNC1;
            end
        endcase
    end

endmodule

### rtl/core/cfpr_dp.sv
module cfpr_dp
    import cfpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_DATA_W-1:0]  out_data,
    output logic                   out_has_payload,
    output logic                   out_last
);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] held_type_reg;
    logic [LEN_W-1:0]  held_length_reg;
    logic [LEN_W-1:0]  fill_index_reg;
    logic [BYTE_W-1:0] crc_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [BYTE_W-1:0] rd_data;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_type_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_has_payload_reg;
    logic              out_last_reg;

    logic [LEN_W-1:0]  fill_plus;
    logic              held_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC1_RESET;
            sync_second_reg <= SYNC2_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_type)
        begin
            held_type_reg <= rx_byte;
            crc_reg       <= crc8_feed('0, rx_byte);
        end
        if (cmd.load_len)
        begin
            held_length_reg <= rx_byte[LEN_W-1:0];
            fill_index_reg  <= '0;
            crc_reg         <= crc8_feed(crc_reg, rx_byte);
        end
        if (cmd.store_byte)
        begin
            fill_index_reg <= fill_plus;
            crc_reg        <= crc8_feed(crc_reg, rx_byte);
        end
        if (cmd.rd_start)
        begin
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    cfpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store_byte),
        .wr_addr (fill_index_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign fill_plus = fill_index_reg + 1'b1;
    assign held_zero = (held_length_reg == '0);

    always_comb
    begin
        status.sync1_hit = (rx_byte == sync_first_reg);
        status.sync2_hit = (rx_byte == sync_second_reg);
        status.len_zero  = (rx_byte == '0);
        status.len_fits  = ({1'b0, rx_byte} <= (BYTE_W + 1)'(PAYLOAD_MAX));
        status.fill_done = (fill_plus >= held_length_reg);
        status.crc_ok    = (rx_byte == crc_reg);
        status.rd_last   = held_zero
                           || ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == held_length_reg);
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_type_reg        <= held_type_reg;
            out_length_reg      <= held_length_reg;
            out_has_payload_reg <= !held_zero;
            out_index_reg       <= held_zero ? '0 : IDX_W'(rd_idx_reg);
            out_byte_reg        <= held_zero ? '0 : rd_data;
            out_last_reg        <= status.rd_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_has_payload = out_has_payload_reg;
    assign out_last        = out_last_reg;
    assign out_data        = {{(OUT_DATA_W - 2 * BYTE_W - LEN_W - IDX_W){1'b0}},
                              out_byte_reg, out_index_reg, out_length_reg, out_type_reg};

endmodule

### rtl/core/crc8_framed_packet_receiver.sv
// Framed packet receiver with CRC-8 check.
// The slave stream takes one received byte per beat. The block hunts for the
// two start-of-frame bytes, then reads type, length, payload and a CRC-8 byte
// (polynomial 0x07, initial value zero, over type, length and payload).
// While parsing, one byte is accepted in every cycle.
// After a good CRC byte, the master stream gives one beat per payload byte, or
// one beat for an empty frame, with tlast on the final beat. A bad CRC or a
// length above the buffer size gives no beat, and the hunt restarts.
// After the CRC beat is accepted, each result passes through the registered read
// of the payload memory and then the load of the output register, which waits
// until the output register has room. No byte is accepted until the final result
// of the frame has been loaded.
// When the master side stalls, the readout waits with the result held.
// The configuration channel writes the two start-of-frame bytes and is always
// ready; the user has it written only while the block is idle (unenforced).
// Reset returns the parser to the hunt, sets the start-of-frame bytes to 0xAA
// and 0x55 and empties the output register.
`include "crc8_framed_packet_receiver_macros.svh"

module crc8_framed_packet_receiver
    import cfpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // rx_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // frame_type[7:0], frame_length[13:8], byte_index[18:14], payload_byte[26:19]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tuser,   // has_payload
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cfpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cfpr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (s_axis_tdata),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata),
        .out_has_payload (m_axis_tuser),
        .out_last        (m_axis_tlast)
    );

    `CFPR_ASSERT_SAME(a_load_needs_room, cmd.load_out, status.out_free)
    `CFPR_ASSERT_SAME(a_store_on_beat, cmd.store_byte, s_axis_tvalid && s_axis_tready)
    `CFPR_ASSERT_SAME(a_no_input_in_readout, cmd.load_out, !s_axis_tready)
    `CFPR_ASSERT_NEXT(a_load_shows_result, cmd.load_out, m_axis_tvalid)

endmodule

### tb/frame_result_monitor.sv
`timescale 1ns / 100ps

module frame_result_monitor
    import cfpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   m_axis_tuser,
    input  logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output int                     fail_count,
    output int                     pending
);

    localparam int LEN_LSB  = BYTE_W;
    localparam int IDX_LSB  = LEN_LSB + LEN_W;
    localparam int DATA_LSB = IDX_LSB + IDX_W;

    typedef struct {
        logic [BYTE_W-1:0] frame_type;
        logic [LEN_W-1:0]  frame_length;
        logic              has_payload;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } frame_beat_t;

    frame_beat_t       expected_beats[$];
    state_t            hunt_phase;
    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] sync_b;
    logic [BYTE_W-1:0] hdr_type;
    logic [BYTE_W-1:0] hdr_len;
    logic [6:0]        fill_count;
    logic [BYTE_W-1:0] crc_acc;
    logic [BYTE_W-1:0] payload_mem [PAYLOAD_MAX];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [BYTE_W-1:0] crc_advance(input logic [BYTE_W-1:0] acc,
                                                      input logic [BYTE_W-1:0] value);
        logic [BYTE_W-1:0] r;
        r = acc ^ value;
        repeat (BYTE_W)
        begin
            r = r[BYTE_W-1] ? ((r << 1) ^ 8'h07) : (r << 1);
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    task automatic emit_frame();
        frame_beat_t beat;
        beat.frame_type = hdr_type;
        if (hdr_len == 0)
        begin
            beat.frame_length = '0;
            beat.has_payload  = 1'b0;
            beat.byte_index   = '0;
            beat.payload_byte = '0;
            beat.last         = 1'b1;
            expected_beats.push_back(beat);
        end
        else
        begin
            for (int k = 0; k < hdr_len; k++)
            begin
                beat.frame_length = hdr_len[LEN_W-1:0];
                beat.has_payload  = 1'b1;
                beat.byte_index   = k[IDX_W-1:0];
                beat.payload_byte = payload_mem[k];
                beat.last         = (k + 1 == hdr_len);
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        case (hunt_phase)
            ST_SYNC1:
            begin
                if (b == sync_a)
                begin
                    hunt_phase = ST_SYNC2;
                end
            end
            ST_SYNC2:
            begin
                hunt_phase = (b == sync_b) ? ST_TYPE : ST_SYNC1;
            end
            ST_TYPE:
            begin
                hdr_type   = b;
                crc_acc    = crc_advance('0, b);
                hunt_phase = ST_LEN;
            end
            ST_LEN:
            begin
                hdr_len    = b;
                fill_count = '0;
                crc_acc    = crc_advance(crc_acc, b);
                if (b == 0)
                begin
                    hunt_phase = ST_CRC;
                end
                else if (b <= PAYLOAD_MAX)
                begin
                    hunt_phase = ST_PAYLOAD;
                end
                else
                begin
                    hunt_phase = ST_SYNC1;
                end
            end
            ST_PAYLOAD:
            begin
                payload_mem[fill_count[ADDR_W-1:0]] = b;
                crc_acc    = crc_advance(crc_acc, b);
                fill_count = fill_count + 1'b1;
                if (fill_count >= hdr_len)
                begin
                    hunt_phase = ST_CRC;
                end
            end
            ST_CRC:
            begin
                hunt_phase = ST_SYNC1;
                if (b == crc_acc)
                begin
                    emit_frame();
                end
            end
            default:
            begin
                hunt_phase = ST_SYNC1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            hunt_phase = ST_SYNC1;
            sync_a     = SYNC1_RESET;
            sync_b     = SYNC2_RESET;
            hdr_type   = '0;
            hdr_len    = '0;
            fill_count = '0;
            crc_acc    = '0;
            expected_beats.delete();
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with no expectation waiting: tdata 0x%0h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("frame_type", want.frame_type, m_axis_tdata[BYTE_W-1:0]);
                    check_field("frame_length", want.frame_length,
                                m_axis_tdata[LEN_LSB +: LEN_W]);
                    check_field("has_payload", want.has_payload, m_axis_tuser);
                    check_field("byte_index", want.byte_index, m_axis_tdata[IDX_LSB +: IDX_W]);
                    check_field("payload_byte", want.payload_byte,
                                m_axis_tdata[DATA_LSB +: BYTE_W]);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SYNC_FIRST)
                begin
                    sync_a = cfg_data;
                end
                else if (cfg_index == REG_SYNC_SECOND)
                begin
                    sync_b = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_byte(s_axis_tdata);
            end
            pending = expected_beats.size();
        end
    end

endmodule

### tb/tb_crc8_framed_packet_receiver.sv
`timescale 1ns / 100ps

module tb_crc8_framed_packet_receiver
    import cfpr_pkg::*;
();

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = REG_SYNC_FIRST;
    logic [BYTE_W-1:0]      cfg_data      = '0;

    int                fail_count;
    int                pending;
    int                tx_idle_pct = 17;
    int                rx_idle_pct = 60;
    int                bytes_sent  = 0;
    bit                hold_request = 1'b0;
    int                hold_left   = 0;
    logic [BYTE_W-1:0] cur_sync1   = SYNC1_RESET;
    logic [BYTE_W-1:0] cur_sync2   = SYNC2_RESET;

    crc8_framed_packet_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_result_monitor u_frame_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver stalls at random, or for a long counted stretch on request.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [BYTE_W-1:0] frame_crc_step(input logic [BYTE_W-1:0] acc,
                                                         input logic [BYTE_W-1:0] value);
        logic [BYTE_W-1:0] r;
        r = acc ^ value;
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (r[BYTE_W-1])
            begin
                r = (r << 1) ^ 8'h07;
            end
            else
            begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // A negative body_fill gives random payload; keep cuts the payload short.
    task automatic send_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] flen,
                              input bit bad_crc, input int body_fill, input int keep);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        send_byte(cur_sync1);
        send_byte(cur_sync2);
        send_byte(ftype);
        send_byte(flen);
        crc = frame_crc_step(frame_crc_step(8'h00, ftype), flen);
        if (flen > PAYLOAD_MAX)
        begin
            return;
        end
        for (int k = 0; k < flen; k++)
        begin
            if (k >= keep)
            begin
                return;
            end
            b = (body_fill < 0) ? 8'($urandom) : body_fill[BYTE_W-1:0];
            send_byte(b);
            crc = frame_crc_step(crc, b);
        end
        if (bad_crc)
        begin
            crc = crc ^ (8'h01 << $urandom_range(7));
        end
        send_byte(crc);
    endtask

    task automatic run_random(input int until_count);
        int                pick;
        logic [BYTE_W-1:0] len;
        while (bytes_sent < until_count)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(7) == 0) ? 8'($urandom_range(PAYLOAD_MAX))
                                            : 8'($urandom_range(6));
            if (pick < 70)
            begin
                send_frame(8'($urandom), len, 1'b0, -1, 64);
            end
            else if (pick < 80)
            begin
                send_frame(8'($urandom), len, 1'b1, -1, 64);
            end
            else if (pick < 85)
            begin
                send_frame(8'($urandom), 8'($urandom_range(255, PAYLOAD_MAX + 1)), 1'b0, -1, 64);
            end
            else if (pick < 90)
            begin
                send_byte(cur_sync1);
                send_byte(cur_sync2 ^ 8'($urandom_range(255, 1)));
            end
            else if (pick < 95)
            begin
                send_frame(8'($urandom), 8'($urandom_range(8, 2)), 1'b0, -1,
                           $urandom_range(1));
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    send_byte(8'($urandom));
                end
            end
        end
    endtask

    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(negedge clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        cfg_write(REG_SYNC_FIRST, first);
        cfg_write(REG_SYNC_SECOND, second);
        cfg_valid <= 1'b0;
        cur_sync1 = first;
        cur_sync2 = second;
    endtask

    initial
    begin
        repeat (12)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(8'h00, 8'd0, 1'b0, 0, 64);
        // A repeated first sync byte aborts the pair and is not taken as a new start.
        send_byte(cur_sync1);
        send_byte(cur_sync1);
        send_byte(cur_sync2);
        send_frame(8'hFF, 8'd1, 1'b0, 8'hFF, 64);
        send_frame(8'h5A, 8'd2, 1'b1, 8'h00, 64);
        send_frame(8'h12, 8'(PAYLOAD_MAX + 1), 1'b0, -1, 64);
        send_frame(8'h34, 8'hFF, 1'b0, -1, 64);
        send_frame(8'hA5, 8'd3, 1'b0, 8'h00, 64);
        run_random(120);
        finish_phase();

        set_sync(8'h00, 8'hFF);
        tx_idle_pct = 60;
        rx_idle_pct = 17;
        send_frame(8'h0F, 8'(PAYLOAD_MAX), 1'b0, -1, 64);
        run_random(240);
        finish_phase();

        set_sync(8'h3C, 8'h3C);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        send_frame(8'hC3, 8'(PAYLOAD_MAX), 1'b0, -1, 64);
        send_frame(8'h3C, 8'(PAYLOAD_MAX), 1'b0, -1, 64);
        send_frame(8'h81, 8'd5, 1'b0, -1, 64);
        run_random(350);
        finish_phase();

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
